[src/pev_pkg.sv]
// ----------------------------------------------------------------------------
// Polynomial evaluator package
// Shared widths, defaults and saturation limits for the Horner pipeline.
// ----------------------------------------------------------------------------
package pev_pkg;

    localparam int DATA_W        = 32;
    localparam int LIMB_W        = 32;
    localparam int NUM_REGS      = 8;
    localparam int REG_IDX_W     = 3;
    localparam int DEG_W         = 3;
    localparam int CNT_W         = 4;

    localparam int NUM_COEFS_DEF = 8;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [DATA_W-1:0] t_data;

    localparam t_data SAT_MAX = 32'sh7FFF_FFFF;
    localparam t_data SAT_MIN = 32'sh8000_0000;

endpackage

[src/pev_step.sv]
// ----------------------------------------------------------------------------
// One Horner step
// Multiplies the exact accumulator by x one 32-bit limb per stage and adds the
// next coefficient, aligned to the growing fraction, giving an exact result.
// ----------------------------------------------------------------------------
module pev_step #(
    parameter int TERMS     = 1,
    parameter int FRAC_BITS = pev_pkg::FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    output logic                                         o_ready,
    input  logic signed [pev_pkg::LIMB_W*TERMS-1:0]      i_acc,
    input  pev_pkg::t_data                               i_x,
    input  pev_pkg::t_data                               i_coef,
    output logic                                         o_valid,
    input  logic                                         i_ready,
    output logic signed [pev_pkg::LIMB_W*(TERMS+1)-1:0]  o_acc,
    output pev_pkg::t_data                               o_x
);

    localparam int LW    = pev_pkg::LIMB_W;
    localparam int IN_W  = LW * TERMS;
    localparam int OUT_W = LW * (TERMS + 1);
    localparam int PW    = 2 * LW + 1;
    localparam int LAST  = TERMS + 1;

    logic                    r_v  [LAST+1];
    logic                    w_en [LAST+1];
    pev_pkg::t_data          r_x  [LAST+1];
    logic signed [IN_W-1:0]  r_a  [TERMS];
    logic signed [PW-1:0]    r_p  [1:TERMS];
    logic signed [OUT_W-1:0] r_s  [1:LAST];

    // A stage may load when it is empty or when its content moves on.
    genvar j;
    generate
        for (j = 0; j < LAST; j++) begin : g_en
            assign w_en[j] = !r_v[j] || w_en[j+1];
        end
    endgenerate
    assign w_en[LAST] = !r_v[LAST] || i_ready;
    assign o_ready    = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0] && i_valid) begin
            r_a[0] <= i_acc;
            r_x[0] <= i_x;
        end
    end

    generate
        for (j = 1; j <= LAST; j++) begin : g_stage
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else if (w_en[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en[j] && r_v[j-1]) begin
                    r_x[j] <= r_x[j-1];
                end
            end

            if (j <= TERMS) begin : g_mul
                localparam int LO = LW * (j - 1);
                logic signed [LW:0] w_limb;

                // Only the top limb carries the sign of the accumulator.
                if (j == TERMS) begin : g_top
                    assign w_limb = signed'({r_a[j-1][LO+LW-1], r_a[j-1][LO +: LW]});
                end else begin : g_low
                    assign w_limb = signed'({1'b0, r_a[j-1][LO +: LW]});
                end

                always_ff @(posedge i_clk) begin
                    if (w_en[j] && r_v[j-1]) begin
                        r_p[j] <= w_limb * r_x[j-1];
                    end
                end

                if (j < TERMS) begin : g_pass
                    always_ff @(posedge i_clk) begin
                        if (w_en[j] && r_v[j-1]) begin
                            r_a[j] <= r_a[j-1];
                        end
                    end
                end

                if (j == 1) begin : g_init
                    always_ff @(posedge i_clk) begin
                        if (w_en[j] && r_v[j-1]) begin
                            r_s[j] <= OUT_W'(i_coef) <<< (FRAC_BITS * TERMS);
                        end
                    end
                end else begin : g_acc
                    always_ff @(posedge i_clk) begin
                        if (w_en[j] && r_v[j-1]) begin
                            r_s[j] <= r_s[j-1] + (OUT_W'(r_p[j-1]) <<< (LW * (j - 2)));
                        end
                    end
                end
            end else begin : g_fin
                always_ff @(posedge i_clk) begin
                    if (w_en[j] && r_v[j-1]) begin
                        r_s[j] <= r_s[j-1] + (OUT_W'(r_p[j-1]) <<< (LW * (j - 2)));
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_v[LAST];
    assign o_acc   = r_s[LAST];
    assign o_x     = r_x[LAST];

endmodule

[src/polynomial_evaluator_unit.sv]
// ----------------------------------------------------------------------------
// Polynomial evaluator unit
// Evaluates a polynomial of up to degree 7 in Q16.16 by Horner's rule.
// ----------------------------------------------------------------------------
// Usage: the eight coefficients are written through the configuration port
// while no request is in flight. Each request on the input channel carries one
// point x; each response carries the rounded, saturated value, an overflow
// flag, the degree and the nonzero coefficient count.
// Both channels use valid and ready. One request is accepted per cycle unless
// the pipeline is stalled. Horner step m takes m + 2 stages: one input stage,
// one stage per 32-bit limb of the accumulator with a single 33x32 multiplier,
// and a final add. Rounding and saturation take two more stages.
// Reset clears the coefficients and all valid bits. When the receiver stalls,
// the output holds and stages fill behind it, so requests are still taken
// until the pipeline is full.
// ----------------------------------------------------------------------------
module polynomial_evaluator_unit #(
    parameter int NUM_COEFS = pev_pkg::NUM_COEFS_DEF,
    parameter int FRAC_BITS = pev_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [pev_pkg::REG_IDX_W-1:0]  i_cfg_index,
    input  pev_pkg::t_data                 i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pev_pkg::t_data                 i_x_point,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pev_pkg::t_data                 o_poly_value,
    output logic                           o_overflow,
    output logic [pev_pkg::DEG_W-1:0]      o_poly_degree,
    output logic [pev_pkg::CNT_W-1:0]      o_nonzero_count
);

    localparam int LW  = pev_pkg::LIMB_W;
    localparam int DW  = pev_pkg::DATA_W;
    localparam int AW  = LW * NUM_COEFS;
    localparam int RW  = AW + 1;
    localparam int RSH = FRAC_BITS * (NUM_COEFS - 1);
    localparam int HSH = (RSH > 0) ? RSH - 1 : 0;
    localparam logic signed [RW-1:0] HALF = (RSH > 0) ? (RW'(1) <<< HSH) : '0;

    pev_pkg::t_data r_coef [pev_pkg::NUM_REGS];

    logic [AW-1:0]   w_acc   [1:NUM_COEFS];
    logic            w_valid [1:NUM_COEFS];
    logic            w_ready [1:NUM_COEFS];
    pev_pkg::t_data  w_x     [1:NUM_COEFS-1];

    logic                        r_rv;
    logic signed [RW-1:0]        r_rnd;
    logic                        w_en_rnd;
    logic                        w_en_out;
    logic signed [RW-1:0]        w_sh;
    logic [RW-DW:0]              w_hi;
    logic                        w_fits;
    logic [pev_pkg::DEG_W-1:0]   w_deg;
    logic [pev_pkg::CNT_W-1:0]   w_cnt;

    logic                        r_ov;
    pev_pkg::t_data              r_val;
    logic                        r_ovf;
    logic [pev_pkg::DEG_W-1:0]   r_deg;
    logic [pev_pkg::CNT_W-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pev_pkg::NUM_REGS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    assign w_acc[1]   = AW'(r_coef[NUM_COEFS-1]);
    assign w_valid[1] = i_in_valid;
    assign w_x[1]     = i_x_point;
    assign o_in_ready = w_ready[1];

    genvar m;
    generate
        for (m = 1; m < NUM_COEFS; m++) begin : g_step
            logic signed [LW*(m+1)-1:0] w_out;

            if (m < NUM_COEFS - 1) begin : g_mid
                pev_step #(
                    .TERMS     (m),
                    .FRAC_BITS (FRAC_BITS)
                ) u_step (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_valid (w_valid[m]),
                    .o_ready (w_ready[m]),
                    .i_acc   (w_acc[m][LW*m-1:0]),
                    .i_x     (w_x[m]),
                    .i_coef  (r_coef[NUM_COEFS-1-m]),
                    .o_valid (w_valid[m+1]),
                    .i_ready (w_ready[m+1]),
                    .o_acc   (w_out),
                    .o_x     (w_x[m+1])
                );
            end else begin : g_last
                pev_step #(
                    .TERMS     (m),
                    .FRAC_BITS (FRAC_BITS)
                ) u_step (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_valid (w_valid[m]),
                    .o_ready (w_ready[m]),
                    .i_acc   (w_acc[m][LW*m-1:0]),
                    .i_x     (w_x[m]),
                    .i_coef  (r_coef[NUM_COEFS-1-m]),
                    .o_valid (w_valid[m+1]),
                    .i_ready (w_ready[m+1]),
                    .o_acc   (w_out),
                    .o_x     ()
                );
            end

            assign w_acc[m+1] = AW'(w_out);
        end
    endgenerate

    assign w_en_out           = !r_ov || i_out_ready;
    assign w_en_rnd           = !r_rv || w_en_out;
    assign w_ready[NUM_COEFS] = w_en_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else if (w_en_rnd) begin
            r_rv <= w_valid[NUM_COEFS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_rnd && w_valid[NUM_COEFS]) begin
            r_rnd <= RW'(signed'(w_acc[NUM_COEFS])) + HALF;
        end
    end

    assign w_sh   = r_rnd >>> RSH;
    assign w_hi   = w_sh[RW-1:DW-1];
    assign w_fits = (&w_hi) || !(|w_hi);

    always_comb begin
        w_deg = '0;
        w_cnt = '0;
        for (int i = 0; i < NUM_COEFS; i++) begin
            if (r_coef[pev_pkg::REG_IDX_W'(i)] != '0) begin
                w_cnt = w_cnt + pev_pkg::CNT_W'(1);
                w_deg = pev_pkg::DEG_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en_out) begin
            r_ov <= r_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out && r_rv) begin
            r_ovf <= !w_fits;
            r_deg <= w_deg;
            r_cnt <= w_cnt;
            if (w_fits) begin
                r_val <= w_sh[DW-1:0];
            end else if (r_rnd[RW-1]) begin
                r_val <= pev_pkg::SAT_MIN;
            end else begin
                r_val <= pev_pkg::SAT_MAX;
            end
        end
    end

    assign o_out_valid     = r_ov;
    assign o_poly_value    = r_val;
    assign o_overflow      = r_ovf;
    assign o_poly_degree   = r_deg;
    assign o_nonzero_count = r_cnt;

endmodule

[src/pev_checker.sv]
// ----------------------------------------------------------------------------
// Polynomial evaluator checker
// Port-level properties of the evaluator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pev_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input pev_pkg::t_data                 o_poly_value,
    input logic                           o_overflow,
    input logic [pev_pkg::DEG_W-1:0]      o_poly_degree,
    input logic [pev_pkg::CNT_W-1:0]      o_nonzero_count
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_poly_value)
            && $stable(o_overflow))
        else $error("stalled response changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request refused with an empty output stage");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |->
            (o_poly_value == pev_pkg::SAT_MAX) || (o_poly_value == pev_pkg::SAT_MIN))
        else $error("overflow flagged on an unsaturated value");

    a_degree_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_nonzero_count <= ({1'b0, o_poly_degree} + pev_pkg::CNT_W'(1)))
            && ((o_nonzero_count != '0) || (o_poly_degree == '0)))
        else $error("degree and nonzero count disagree");

endmodule

bind polynomial_evaluator_unit pev_checker u_pev_checker (.*);

[dv/tb_polynomial_evaluator_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polynomial evaluator unit testbench
// Streams evaluation points through the Horner pipeline under several sets of
// coefficients. Results are checked against table values where directed rows
// give them, else against an exact wide-integer evaluation with rounding,
// saturation, degree and nonzero count. Directed rows come first, then random
// phases. Sender bursts; receiver stalls, once in a pipeline-filling hold-off.
// ----------------------------------------------------------------------------
module tb_polynomial_evaluator_unit;

    localparam int    CLK_PERIOD   = 10;
    localparam int    NUM_COEFS    = pev_pkg::NUM_COEFS_DEF;
    localparam int    FRAC_BITS    = pev_pkg::FRAC_BITS_DEF;
    localparam int    ACC_W        = pev_pkg::LIMB_W * (NUM_COEFS + 2);
    localparam int    RND_SHIFT    = FRAC_BITS * (NUM_COEFS - 1);
    localparam int    LATENCY      = (NUM_COEFS - 1) * NUM_COEFS / 2 + 2 * (NUM_COEFS - 1) + 2;
    localparam int    NUM_PHASES   = 8;
    localparam int    PHASE_POINTS = 180;
    localparam int    LONG_HOLD    = 400;
    localparam int    HOLD_AFTER   = 300;
    localparam int    TIMEOUT_NS   = 4_000_000;
    localparam pev_pkg::t_data ONE  = 32'sh0001_0000;
    localparam pev_pkg::t_data HALF = 32'sh0000_8000;

    localparam logic signed [ACC_W-1:0] ACC_ONE = 1;

    typedef struct packed {
        pev_pkg::t_data                value;
        logic                          ovf;
        logic [pev_pkg::DEG_W-1:0]     deg;
        logic [pev_pkg::CNT_W-1:0]     cnt;
    } t_poly_result;

    typedef enum logic [3:0] {
        DS_RESET, DS_C0_MAX, DS_IDENT, DS_HALF, DS_X7, DS_ALL_MAX, DS_ALL_MIN, DS_MIXED
    } t_dir_set;

    typedef enum logic [1:0] {CK_SMALL, CK_MIXED, CK_SPARSE, CK_EXTREME} t_coef_kind;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC} t_rx_mode;

    typedef struct packed {
        t_dir_set        cset;
        pev_pkg::t_data  x;
        logic            known;
        t_poly_result    res;
    } t_dir_row;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [pev_pkg::REG_IDX_W-1:0]  cfg_index   = '0;
    pev_pkg::t_data                 cfg_data    = '0;
    logic                           in_valid    = 1'b0;
    logic                           in_ready;
    pev_pkg::t_data                 x_point     = '0;
    logic                           out_valid;
    logic                           out_ready   = 1'b0;
    pev_pkg::t_data                 poly_value;
    logic                           overflow;
    logic [pev_pkg::DEG_W-1:0]      poly_degree;
    logic [pev_pkg::CNT_W-1:0]      nonzero_count;

    pev_pkg::t_data  model_coefs  [NUM_COEFS];
    pev_pkg::t_data  staged_coefs [NUM_COEFS];
    t_poly_result    pending_values [$];
    t_dir_row        dir_rows [$];
    t_coef_kind      phase_plan [NUM_PHASES] = '{CK_SMALL, CK_MIXED, CK_SPARSE, CK_EXTREME,
                                                 CK_SMALL, CK_SPARSE, CK_MIXED, CK_SMALL};

    int  errors          = 0;
    int  results_seen    = 0;
    int  points_sent     = 0;
    int  saturated_count = 0;
    int  in_stall_cycles = 0;
    int  coef_loads      = 0;
    int  burst_left      = 0;

    polynomial_evaluator_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_x_point       (x_point),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_poly_value    (poly_value),
        .o_overflow      (overflow),
        .o_poly_degree   (poly_degree),
        .o_nonzero_count (nonzero_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic t_poly_result eval_poly(input pev_pkg::t_data x);
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] xw;
        logic signed [ACC_W-1:0] cw;
        t_poly_result            r;
        int                      k;
        xw  = x;
        acc = model_coefs[NUM_COEFS-1];
        for (k = NUM_COEFS - 2; k >= 0; k--) begin
            cw  = model_coefs[k];
            acc = acc * xw + (cw <<< (FRAC_BITS * (NUM_COEFS - 1 - k)));
        end
        acc = acc + (ACC_ONE <<< (RND_SHIFT - 1));
        acc = acc >>> RND_SHIFT;
        if (acc[ACC_W-1:pev_pkg::DATA_W-1]
                == {(ACC_W - pev_pkg::DATA_W + 1){acc[pev_pkg::DATA_W-1]}}) begin
            r.value = acc[pev_pkg::DATA_W-1:0];
            r.ovf   = 1'b0;
        end else begin
            r.value = acc[ACC_W-1] ? pev_pkg::SAT_MIN : pev_pkg::SAT_MAX;
            r.ovf   = 1'b1;
        end
        r.deg = '0;
        r.cnt = '0;
        for (k = 0; k < NUM_COEFS; k++) begin
            if (model_coefs[k] != 0) begin
                r.cnt = r.cnt + 1'b1;
                r.deg = pev_pkg::DEG_W'(k);
            end
        end
        return r;
    endfunction

    function automatic pev_pkg::t_data dir_coef(input t_dir_set s, input int idx);
        case (s)
            DS_C0_MAX:  return (idx == 0) ? pev_pkg::SAT_MAX : '0;
            DS_IDENT:   return (idx == 1) ? ONE : '0;
            DS_HALF:    return (idx == 1) ? HALF : '0;
            DS_X7:      return (idx == 7) ? ONE : '0;
            DS_ALL_MAX: return pev_pkg::SAT_MAX;
            DS_ALL_MIN: return pev_pkg::SAT_MIN;
            DS_MIXED: begin
                if (idx % 3 == 2)
                    return '0;
                else if (idx % 2 == 1)
                    return -(idx * 32'sh3000);
                else
                    return ONE + idx * 32'sh0123;
            end
            default:    return '0;
        endcase
    endfunction

    function automatic pev_pkg::t_data rand_span(input int span);
        return pev_pkg::t_data'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic pev_pkg::t_data pick_extreme();
        case ($urandom_range(0, 6))
            0:       return pev_pkg::SAT_MAX;
            1:       return pev_pkg::SAT_MIN;
            2:       return -1;
            3:       return 1;
            4:       return ONE;
            5:       return -ONE;
            default: return '0;
        endcase
    endfunction

    function automatic pev_pkg::t_data gen_coef(input t_coef_kind kind);
        int unsigned    roll;
        pev_pkg::t_data v;
        roll = $urandom_range(0, 99);
        case (kind)
            CK_SMALL:   return (roll < 10) ? '0 : rand_span(1 << 17);
            CK_SPARSE:  return (roll < 60) ? '0 : rand_span(1 << 18);
            CK_EXTREME: return (roll < 15) ? '0 : pick_extreme();
            default: begin
                v = $urandom;
                if (roll < 20)
                    return '0;
                else if (roll < 50)
                    return rand_span(1 << 17);
                else if (roll < 80)
                    return v >>> $urandom_range(0, 31);
                else
                    return v;
            end
        endcase
    endfunction

    function automatic pev_pkg::t_data gen_x();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return pev_pkg::t_data'($urandom);
        else if (roll < 65)
            return rand_span(1 << 17);
        else if (roll < 85)
            return rand_span(1 << 8);
        else
            return pick_extreme();
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("ERROR at %0t ns: %s got %0d, expected %0d", $time, field, got, want);
        errors++;
    endtask

    task automatic add_row(input t_dir_set s, input pev_pkg::t_data x, input logic known,
                           input pev_pkg::t_data v, input logic ovf, input int deg,
                           input int cnt);
        t_dir_row row;
        row.cset      = s;
        row.x         = x;
        row.known     = known;
        row.res.value = v;
        row.res.ovf   = ovf;
        row.res.deg   = pev_pkg::DEG_W'(deg);
        row.res.cnt   = pev_pkg::CNT_W'(cnt);
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic idle_cycles(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 12));
        end
        burst_left--;
    endtask

    task automatic load_coefs();
        int i;
        in_valid <= 1'b0;
        while (pending_values.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        for (i = 0; i < NUM_COEFS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= pev_pkg::REG_IDX_W'(i);
            cfg_data  <= staged_coefs[i];
            @(posedge clk);
            model_coefs[i] = staged_coefs[i];
        end
        cfg_wr_en <= 1'b0;
        coef_loads++;
    endtask

    task automatic send_point(input pev_pkg::t_data x, input logic known,
                              input t_poly_result given);
        in_valid <= 1'b1;
        x_point  <= x;
        forever begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        pending_values.insert(pending_values.size(), known ? given : eval_poly(x));
        points_sent++;
    endtask

    initial begin
        int           i;
        int           p;
        int           n;
        t_dir_set     cur;
        t_poly_result none;
        none = '0;
        for (i = 0; i < NUM_COEFS; i++)
            model_coefs[i] = '0;

        add_row(DS_RESET,   32'sh0,          1'b1, 32'sh0,           1'b0, 0, 0);
        add_row(DS_RESET,   pev_pkg::SAT_MAX, 1'b1, 32'sh0,          1'b0, 0, 0);
        add_row(DS_RESET,   pev_pkg::SAT_MIN, 1'b1, 32'sh0,          1'b0, 0, 0);
        add_row(DS_C0_MAX,  pev_pkg::SAT_MAX, 1'b1, pev_pkg::SAT_MAX, 1'b0, 0, 1);
        add_row(DS_C0_MAX,  pev_pkg::SAT_MIN, 1'b1, pev_pkg::SAT_MAX, 1'b0, 0, 1);
        add_row(DS_IDENT,   pev_pkg::SAT_MAX, 1'b1, pev_pkg::SAT_MAX, 1'b0, 1, 1);
        add_row(DS_IDENT,   pev_pkg::SAT_MIN, 1'b1, pev_pkg::SAT_MIN, 1'b0, 1, 1);
        add_row(DS_IDENT,   -32'sd1,         1'b1, -32'sd1,          1'b0, 1, 1);
        add_row(DS_HALF,    32'sd1,          1'b1, 32'sd1,           1'b0, 1, 1);
        add_row(DS_HALF,    -32'sd1,         1'b1, 32'sh0,           1'b0, 1, 1);
        add_row(DS_HALF,    32'sd3,          1'b1, 32'sd2,           1'b0, 1, 1);
        add_row(DS_X7,      32'sh0002_0000,  1'b1, 32'sh0080_0000,   1'b0, 7, 1);
        add_row(DS_X7,      -32'sh0002_0000, 1'b1, -32'sh0080_0000,  1'b0, 7, 1);
        add_row(DS_X7,      32'sh0008_0000,  1'b1, pev_pkg::SAT_MAX, 1'b1, 7, 1);
        add_row(DS_X7,      -32'sh0008_0000, 1'b1, pev_pkg::SAT_MIN, 1'b1, 7, 1);
        add_row(DS_ALL_MAX, pev_pkg::SAT_MAX, 1'b1, pev_pkg::SAT_MAX, 1'b1, 7, 8);
        add_row(DS_ALL_MAX, 32'sh0,          1'b1, pev_pkg::SAT_MAX, 1'b0, 7, 8);
        add_row(DS_ALL_MAX, pev_pkg::SAT_MIN, 1'b1, pev_pkg::SAT_MIN, 1'b1, 7, 8);
        add_row(DS_ALL_MIN, pev_pkg::SAT_MAX, 1'b1, pev_pkg::SAT_MIN, 1'b1, 7, 8);
        add_row(DS_ALL_MIN, 32'sh0,          1'b1, pev_pkg::SAT_MIN, 1'b0, 7, 8);
        add_row(DS_ALL_MIN, pev_pkg::SAT_MIN, 1'b1, pev_pkg::SAT_MAX, 1'b1, 7, 8);
        add_row(DS_MIXED,   ONE,             1'b0, '0,               1'b0, 0, 0);
        add_row(DS_MIXED,   -ONE,            1'b0, '0,               1'b0, 0, 0);
        add_row(DS_MIXED,   32'sh0001_8000,  1'b0, '0,               1'b0, 0, 0);
        add_row(DS_MIXED,   -32'sd1,         1'b0, '0,               1'b0, 0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur = DS_RESET;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].cset != cur) begin
                for (i = 0; i < NUM_COEFS; i++)
                    staged_coefs[i] = dir_coef(dir_rows[r].cset, i);
                load_coefs();
                cur = dir_rows[r].cset;
            end
            pace();
            send_point(dir_rows[r].x, dir_rows[r].known, dir_rows[r].res);
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            for (i = 0; i < NUM_COEFS; i++)
                staged_coefs[i] = gen_coef(phase_plan[p]);
            load_coefs();
            for (n = 0; n < PHASE_POINTS; n++) begin
                pace();
                send_point(gen_x(), 1'b0, none);
            end
        end

        in_valid <= 1'b0;
        while (pending_values.size() != 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        $display("Summary: %0d points evaluated under %0d coefficient loads, %0d saturated.",
                 points_sent, coef_loads, saturated_count);
        $display("Request side was held off for %0d cycles; %0d results checked, %0d errors.",
                 in_stall_cycles, results_seen, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        t_rx_mode mode;
        int       span;
        int       tick;
        bit       held;
        held = 1'b0;
        tick = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            mode = t_rx_mode'($urandom_range(0, 2));
            span = $urandom_range(20, 150);
            repeat (span) begin
                if (!held && results_seen >= HOLD_AFTER) begin
                    out_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                    held = 1'b1;
                end
                case (mode)
                    RX_OPEN:     out_ready <= 1'b1;
                    RX_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
                    default:     out_ready <= (tick % 4) != 3;
                endcase
                tick++;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        t_poly_result want;
        if (rst_n) begin
            if (in_valid && !in_ready)
                in_stall_cycles++;
            if (out_valid && out_ready) begin
                if (pending_values.size() == 0) begin
                    report_mismatch("unrequested result value", poly_value, 0);
                end else begin
                    want = pending_values.pop_front();
                    results_seen++;
                    if (want.ovf)
                        saturated_count++;
                    if (poly_value !== want.value)
                        report_mismatch("poly_value", poly_value, want.value);
                    if (overflow !== want.ovf)
                        report_mismatch("overflow", overflow, want.ovf);
                    if (poly_degree !== want.deg)
                        report_mismatch("poly_degree", poly_degree, want.deg);
                    if (nonzero_count !== want.cnt)
                        report_mismatch("nonzero_count", nonzero_count, want.cnt);
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding.", pending_values.size());
        $display("Verification failed");
        $finish;
    end

endmodule
